// ===== rtl/brs_pkg.sv =====
package brs_pkg;

    localparam int DEF_MAX_ELEMENTS = 65536;
    localparam int DEF_MAX_BLOCKS   = 512;

    localparam int OPC_W     = 2;
    localparam int IDX_W     = 17;
    localparam int LEN_W     = 9;
    localparam int VAL_W     = 32;
    localparam int REM_W     = 33;
    localparam int ACC_W     = 64;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_W     = 17;

    localparam logic [OPC_W-1:0] OP_LOAD  = 2'd0;
    localparam logic [OPC_W-1:0] OP_ADD   = 2'd1;
    localparam logic [OPC_W-1:0] OP_QUERY = 2'd2;
    localparam logic [OPC_W-1:0] OP_NOP   = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_COUNT  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_LENGTH = 1'b1;

    typedef struct packed {
        logic [OPC_W-1:0]        opcode;
        logic [IDX_W-1:0]        left_index;
        logic [IDX_W-1:0]        right_index;
        logic signed [VAL_W-1:0] operand_value;
    } in_item_t;

    typedef struct packed {
        logic signed [REM_W-1:0] remainder;
        logic                    status;
    } out_item_t;

    typedef enum logic [4:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_CHECK,
        ST_LD_DIV,
        ST_LD_DIV2,
        ST_LD_RD,
        ST_LD_WR,
        ST_ERR,
        ST_ID_L,
        ST_ID_R,
        ST_ID_CAP,
        ST_EDGE_L,
        ST_EDGE_R,
        ST_EDGE_CAP,
        ST_EL_RD,
        ST_EL_CHK,
        ST_EL_MOD,
        ST_EDGE_WB,
        ST_MID_INIT,
        ST_MID_RD,
        ST_MID_CHK,
        ST_MID_MOD,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic latch;
        logic clr_wr;
        logic div_start;
        logic div2_start;
        logic ld_rd;
        logic ld_wr;
        logic rd_l;
        logic rd_r;
        logic cap_sid;
        logic cap_eid;
        logic edge_l;
        logic edge_r;
        logic edge_cap;
        logic el_rd;
        logic el_apply;
        logic mod_cap;
        logic edge_wb;
        logic mid_init;
        logic mid_rd;
        logic mid_apply;
        logic out_ok;
        logic out_err;
    } cmd_t;

    typedef struct packed {
        logic             clr_last;
        logic             div_done;
        logic             mod_done;
        logic             bad;
        logic [OPC_W-1:0] opcode;
        logic             same_blk;
        logic             el_in_range;
        logic             el_match;
        logic             mid_more;
        logic             side_right;
    } sts_t;

endpackage

// ===== rtl/brs_divu.sv =====
module brs_divu
    import brs_pkg::*;
#(
    parameter int NW = 64,
    parameter int DW = 32
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [NW-1:0] num,
    input  logic [DW-1:0] den,
    output logic          done,
    output logic [NW-1:0] quo,
    output logic [DW-1:0] rem
);

    localparam int CW = $clog2(NW + 1);

    logic          run_reg;
    logic [CW-1:0] cnt_reg;
    logic          done_reg;
    logic [NW-1:0] quo_reg;
    logic [DW-1:0] rem_reg;
    logic [DW-1:0] den_reg;
    logic [DW:0]   trial;
    logic          ge;

    // restoring division, one quotient bit a cycle
    assign trial = {rem_reg, quo_reg[NW-1]};
    assign ge    = trial >= {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= run_reg && (cnt_reg == CW'(NW - 1));
            if (start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= '0;
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CW'(NW - 1))
                    run_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= num;
            rem_reg <= '0;
            den_reg <= den;
        end
        else if (run_reg)
        begin
            rem_reg <= ge ? DW'(trial - {1'b0, den_reg}) : DW'(trial);
            quo_reg <= {quo_reg[NW-2:0], ge};
        end
    end

    assign done = done_reg;
    assign quo  = quo_reg;
    assign rem  = rem_reg;

endmodule

// ===== rtl/brs_ctrl.sv =====
module brs_ctrl
    import brs_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    input  sts_t sts,
    output cmd_t cmd,
    output logic busy
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_CLEAR;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:    if (sts.clr_last) state_next = ST_IDLE;
            ST_IDLE:     if (start) state_next = ST_CHECK;
            ST_CHECK:
            begin
                case (sts.opcode)
                    OP_LOAD:  state_next = sts.bad ? ST_ERR : ST_LD_DIV;
                    OP_ADD,
                    OP_QUERY: state_next = sts.bad ? ST_ERR : ST_ID_L;
                    default:  state_next = ST_IDLE;
                endcase
            end
            ST_LD_DIV:   if (sts.div_done) state_next = ST_LD_DIV2;
            ST_LD_DIV2:  if (sts.div_done) state_next = ST_LD_RD;
            ST_LD_RD:    state_next = ST_LD_WR;
            ST_LD_WR:    state_next = ST_IDLE;
            ST_ERR:      state_next = ST_IDLE;
            ST_ID_L:     state_next = ST_ID_R;
            ST_ID_R:     state_next = ST_ID_CAP;
            ST_ID_CAP:   state_next = ST_EDGE_L;
            ST_EDGE_L:   state_next = ST_EDGE_CAP;
            ST_EDGE_R:   state_next = ST_EDGE_CAP;
            ST_EDGE_CAP: state_next = ST_EL_RD;
            ST_EL_RD:    state_next = sts.el_in_range ? ST_EL_CHK : ST_EDGE_WB;
            ST_EL_CHK:
            begin
                if (!sts.el_match)
                    state_next = ST_EDGE_WB;
                else if (sts.opcode == OP_QUERY)
                    state_next = ST_EL_MOD;
                else
                    state_next = ST_EL_RD;
            end
            ST_EL_MOD:   if (sts.mod_done) state_next = ST_EL_RD;
            ST_EDGE_WB:
                state_next = (sts.side_right || sts.same_blk) ? ST_DONE : ST_MID_INIT;
            ST_MID_INIT: state_next = ST_MID_RD;
            ST_MID_RD:   state_next = sts.mid_more ? ST_MID_CHK : ST_EDGE_R;
            ST_MID_CHK:  state_next = (sts.opcode == OP_QUERY) ? ST_MID_MOD : ST_MID_RD;
            ST_MID_MOD:  if (sts.mod_done) state_next = ST_MID_RD;
            ST_DONE:     state_next = ST_IDLE;
            default:     state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd  = '0;
        busy = (state_reg != ST_IDLE);
        case (state_reg)
            ST_CLEAR:    cmd.clr_wr = 1'b1;
            ST_IDLE:     cmd.latch = start;
            ST_CHECK:    cmd.div_start = (sts.opcode == OP_LOAD) && !sts.bad;
            ST_LD_DIV:   cmd.div2_start = sts.div_done;
            ST_LD_RD:    cmd.ld_rd = 1'b1;
            ST_LD_WR:    cmd.ld_wr = 1'b1;
            ST_ERR:      cmd.out_err = 1'b1;
            ST_ID_L:     cmd.rd_l = 1'b1;
            ST_ID_R:
            begin
                cmd.cap_sid = 1'b1;
                cmd.rd_r    = 1'b1;
            end
            ST_ID_CAP:   cmd.cap_eid = 1'b1;
            ST_EDGE_L:   cmd.edge_l = 1'b1;
            ST_EDGE_R:   cmd.edge_r = 1'b1;
            ST_EDGE_CAP: cmd.edge_cap = 1'b1;
            ST_EL_RD:    cmd.el_rd = sts.el_in_range;
            ST_EL_CHK:   cmd.el_apply = sts.el_match;
            ST_EL_MOD:   cmd.mod_cap = sts.mod_done;
            ST_EDGE_WB:  cmd.edge_wb = 1'b1;
            ST_MID_INIT: cmd.mid_init = 1'b1;
            ST_MID_RD:   cmd.mid_rd = sts.mid_more;
            ST_MID_CHK:  cmd.mid_apply = 1'b1;
            ST_MID_MOD:  cmd.mod_cap = sts.mod_done;
            ST_DONE:     cmd.out_ok = (sts.opcode == OP_QUERY);
            default:     cmd = '0;
        endcase
    end

    a_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE && start) |=> (state_reg == ST_CHECK))
        else $error("accepted item did not reach the check state");

    a_one_event: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.out_ok, cmd.out_err, cmd.latch}))
        else $error("result and accept collide");

    a_mod_query: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EL_MOD || state_reg == ST_MID_MOD) |-> (sts.opcode == OP_QUERY))
        else $error("modulo wait outside a query");

endmodule

// ===== rtl/brs_dp.sv =====
module brs_dp
    import brs_pkg::*;
#(
    parameter int MAX_ELEMENTS = DEF_MAX_ELEMENTS,
    parameter int MAX_BLOCKS   = DEF_MAX_BLOCKS
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  in_item_t             operation,
    input  logic                 wr_en,
    input  logic [CFG_IDX_W-1:0] wr_index,
    input  logic [CFG_W-1:0]     wr_data,
    input  cmd_t                 cmd,
    output sts_t                 sts,
    output out_item_t            result,
    output logic                 done
);

    localparam int AW  = $clog2(MAX_ELEMENTS);
    localparam int BW  = $clog2(MAX_BLOCKS);
    localparam int IW  = IDX_W + 1;
    localparam int DVW = LEN_W;
    localparam int PW  = 2 * IDX_W + 1;

    // reciprocal for the block-number wrap, exact for any 17-bit numerator
    localparam int     MB_SH  = IDX_W + $clog2(MAX_BLOCKS);
    localparam longint MB_REC = ((longint'(1) << MB_SH) + longint'(MAX_BLOCKS) - longint'(1))
                                / longint'(MAX_BLOCKS);

    // configuration
    logic [IDX_W-1:0] count_reg;
    logic [LEN_W-1:0] len_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= IDX_W'(1);
            len_reg   <= LEN_W'(1);
        end
        else if (wr_en)
        begin
            case (wr_index)
                CFG_COUNT:  count_reg <= wr_data[IDX_W-1:0];
                CFG_LENGTH: len_reg   <= wr_data[LEN_W-1:0];
                default:    count_reg <= count_reg;
            endcase
        end
    end

    // latched item
    logic [OPC_W-1:0] op_reg;
    logic [IW-1:0]    l_reg;
    logic [IW-1:0]    r_reg;
    logic [IW-1:0]    n_reg;
    logic [ACC_W-1:0] v_reg;
    logic [LEN_W-1:0] len_eff_reg;
    logic [ACC_W-1:0] lenv_reg;
    logic [VAL_W-1:0] m_reg;

    // amount times block length; the true product fits in 42 bits
    logic signed [VAL_W+LEN_W:0] lenv_prod;

    assign lenv_prod = $signed(v_reg[VAL_W-1:0]) * $signed({1'b0, len_eff_reg});

    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            op_reg      <= operation.opcode;
            l_reg       <= IW'(operation.left_index);
            r_reg       <= IW'(operation.right_index);
            v_reg       <= {{(ACC_W-VAL_W){operation.operand_value[VAL_W-1]}},
                            operation.operand_value};
            n_reg       <= (32'(count_reg) > MAX_ELEMENTS) ? IW'(MAX_ELEMENTS)
                                                           : IW'(count_reg);
            len_eff_reg <= (len_reg == '0) ? LEN_W'(1) : len_reg;
            m_reg       <= VAL_W'(operation.operand_value) + VAL_W'(1);
        end
        lenv_reg <= {{(ACC_W-VAL_W-LEN_W-1){lenv_prod[VAL_W+LEN_W]}}, lenv_prod};
    end

    logic bad;
    always_comb
    begin
        if (op_reg == OP_LOAD)
            bad = (l_reg == '0) || (l_reg > n_reg);
        else
            bad = (l_reg == '0) || (r_reg > n_reg) || (l_reg > r_reg) ||
                  ((op_reg == OP_QUERY) && v_reg[ACC_W-1]);
    end

    // block number of a load: q = (l-1)/len in the serial divider, then
    // (q+1) mod MAX_BLOCKS by reciprocal multiplication through mb_x_reg, mb_q_reg and mb_r_reg
    logic             div_go;
    logic [IDX_W-1:0] div_num;
    logic [DVW-1:0]   div_den;
    logic             div_done;
    logic [IDX_W-1:0] div_quo;
    logic [DVW-1:0]   div_rem;
    logic [BW-1:0]    blk_ld;
    logic [IDX_W-1:0] mb_x_reg;
    logic [IDX_W-1:0] mb_q_reg;
    logic [BW-1:0]    mb_r_reg;
    logic [2:0]       mb_vld_reg;
    logic [PW-1:0]    mb_prod;
    logic [IDX_W-1:0] mb_qd;

    assign div_go  = cmd.div_start;
    assign div_num = IDX_W'(l_reg - IW'(1));
    assign div_den = len_eff_reg;
    assign blk_ld  = mb_r_reg;

    brs_divu #(.NW(IDX_W), .DW(DVW)) u_blkdiv (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_go),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quo   (div_quo),
        .rem   (div_rem)
    );

    assign mb_prod = PW'(mb_x_reg) * PW'(MB_REC);
    assign mb_qd   = IDX_W'(mb_q_reg * IDX_W'(MAX_BLOCKS));

    always_ff @(posedge clk)
    begin
        if (cmd.div2_start)
            mb_x_reg <= div_quo + IDX_W'(1);
        mb_q_reg <= IDX_W'(mb_prod >> MB_SH);
        mb_r_reg <= BW'(mb_x_reg - mb_qd);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mb_vld_reg <= '0;
        else
            mb_vld_reg <= {mb_vld_reg[1:0], cmd.div2_start};
    end

    // walk registers
    logic [BW-1:0]    sid_reg;
    logic [BW-1:0]    eid_reg;
    logic [BW-1:0]    target_reg;
    logic             side_reg;
    logic [IW-1:0]    i_reg;
    logic [BW:0]      b_reg;
    logic [ACC_W-1:0] pend_q;
    logic [ACC_W-1:0] tot_q;
    logic [ACC_W-1:0] acc_reg;
    logic             neg_reg;
    logic [BW-1:0]    clr_idx_reg;

    // memories
    logic [ACC_W-1:0] elem_mem [MAX_ELEMENTS];
    logic [BW-1:0]    bnt_mem  [MAX_ELEMENTS];
    logic [ACC_W-1:0] pend_mem [MAX_BLOCKS];
    logic [ACC_W-1:0] tot_mem  [MAX_BLOCKS];
    logic [ACC_W-1:0] elem_rd;
    logic [BW-1:0]    bnt_rd;
    logic [ACC_W-1:0] pend_rd;
    logic [ACC_W-1:0] tot_rd;

    logic             is_add;
    logic             is_query;
    logic [AW-1:0]    e_raddr;
    logic [AW-1:0]    e_waddr;
    logic             e_re;
    logic             e_we;
    logic [ACC_W-1:0] e_wdata;
    logic [BW-1:0]    b_raddr;
    logic [BW-1:0]    b_waddr;
    logic             b_re;
    logic             pend_we;
    logic             tot_we;
    logic [ACC_W-1:0] pend_wdata;
    logic [ACC_W-1:0] tot_wdata;

    assign is_add   = (op_reg == OP_ADD);
    assign is_query = (op_reg == OP_QUERY);

    always_comb
    begin
        if (cmd.rd_l)
            e_raddr = AW'(l_reg - IW'(1));
        else if (cmd.rd_r)
            e_raddr = AW'(r_reg - IW'(1));
        else
            e_raddr = AW'(i_reg - IW'(1));
        e_re    = cmd.rd_l || cmd.rd_r || cmd.el_rd;
        e_waddr = cmd.ld_wr ? AW'(l_reg - IW'(1)) : AW'(i_reg - IW'(1));
        e_we    = cmd.ld_wr || (cmd.el_apply && is_add);
        e_wdata = cmd.ld_wr ? v_reg : (elem_rd + v_reg);
    end

    always_ff @(posedge clk)
    begin
        if (e_re)
        begin
            elem_rd <= elem_mem[e_raddr];
            bnt_rd  <= bnt_mem[e_raddr];
        end
        if (e_we)
            elem_mem[e_waddr] <= e_wdata;
        if (cmd.ld_wr)
            bnt_mem[e_waddr] <= blk_ld;
    end

    always_comb
    begin
        if (cmd.ld_rd)
            b_raddr = blk_ld;
        else if (cmd.edge_l)
            b_raddr = sid_reg;
        else if (cmd.edge_r)
            b_raddr = eid_reg;
        else
            b_raddr = b_reg[BW-1:0];
        b_re = cmd.ld_rd || cmd.edge_l || cmd.edge_r || cmd.mid_rd;

        if (cmd.clr_wr)
            b_waddr = clr_idx_reg;
        else if (cmd.ld_wr)
            b_waddr = blk_ld;
        else if (cmd.edge_wb)
            b_waddr = target_reg;
        else
            b_waddr = b_reg[BW-1:0];

        pend_we    = cmd.clr_wr || (cmd.mid_apply && is_add);
        tot_we     = cmd.clr_wr || cmd.ld_wr || (cmd.edge_wb && is_add) ||
                     (cmd.mid_apply && is_add);
        pend_wdata = cmd.clr_wr ? '0 : (pend_rd + v_reg);
        if (cmd.clr_wr)
            tot_wdata = '0;
        else if (cmd.ld_wr)
            tot_wdata = tot_rd + v_reg;
        else if (cmd.edge_wb)
            tot_wdata = tot_q;
        else
            tot_wdata = tot_rd + lenv_reg;
    end

    always_ff @(posedge clk)
    begin
        if (b_re)
        begin
            pend_rd <= pend_mem[b_raddr];
            tot_rd  <= tot_mem[b_raddr];
        end
        if (pend_we)
            pend_mem[b_waddr] <= pend_wdata;
        if (tot_we)
            tot_mem[b_waddr] <= tot_wdata;
    end

    // running sum reduction
    logic [ACC_W-1:0] mod_sum;
    logic [ACC_W-1:0] mod_mag;
    logic             mod_go;
    logic             mod_done;
    logic [ACC_W-1:0] mod_quo;
    logic [VAL_W-1:0] mod_rem;

    assign mod_sum = cmd.mid_apply ? (acc_reg + tot_rd) : (acc_reg + elem_rd + pend_q);
    assign mod_mag = mod_sum[ACC_W-1] ? (~mod_sum + ACC_W'(1)) : mod_sum;
    assign mod_go  = (cmd.el_apply || cmd.mid_apply) && is_query;

    brs_divu #(.NW(ACC_W), .DW(VAL_W)) u_moddiv (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mod_go),
        .num   (mod_mag),
        .den   (m_reg),
        .done  (mod_done),
        .quo   (mod_quo),
        .rem   (mod_rem)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.cap_sid)
            sid_reg <= bnt_rd;
        if (cmd.cap_eid)
            eid_reg <= bnt_rd;
        if (cmd.edge_l)
        begin
            i_reg      <= l_reg;
            target_reg <= sid_reg;
            side_reg   <= 1'b0;
        end
        else if (cmd.edge_r)
        begin
            i_reg      <= r_reg;
            target_reg <= eid_reg;
            side_reg   <= 1'b1;
        end
        else if (cmd.el_apply)
            i_reg <= side_reg ? (i_reg - IW'(1)) : (i_reg + IW'(1));
        if (cmd.edge_cap)
        begin
            pend_q <= pend_rd;
            tot_q  <= tot_rd;
        end
        else if (cmd.el_apply)
            tot_q <= tot_q + v_reg;
        if (cmd.mid_init)
            b_reg <= {1'b0, sid_reg} + (BW+1)'(1);
        else if (cmd.mid_apply)
            b_reg <= b_reg + (BW+1)'(1);
        if (mod_go)
            neg_reg <= mod_sum[ACC_W-1];
        if (cmd.latch)
            acc_reg <= '0;
        else if (cmd.mod_cap)
            acc_reg <= neg_reg ? (~ACC_W'(mod_rem) + ACC_W'(1)) : ACC_W'(mod_rem);
    end

    // clearing pass over the block stores after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            clr_idx_reg <= '0;
        else if (cmd.clr_wr)
            clr_idx_reg <= clr_idx_reg + BW'(1);
    end

    // result register
    logic      done_reg;
    out_item_t result_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= cmd.out_ok || cmd.out_err;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_err)
        begin
            result_reg.remainder <= '0;
            result_reg.status    <= 1'b1;
        end
        else if (cmd.out_ok)
        begin
            result_reg.remainder <= acc_reg[REM_W-1:0];
            result_reg.status    <= 1'b0;
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

    always_comb
    begin
        sts.clr_last    = (clr_idx_reg == BW'(MAX_BLOCKS - 1));
        sts.div_done    = div_done || mb_vld_reg[2];
        sts.mod_done    = mod_done;
        sts.bad         = bad;
        sts.opcode      = op_reg;
        sts.same_blk    = (sid_reg == eid_reg);
        sts.side_right  = side_reg;
        sts.mid_more    = (b_reg < {1'b0, eid_reg});
        sts.el_match    = (sid_reg == eid_reg) || (bnt_rd == target_reg);
        if (sid_reg == eid_reg)
            sts.el_in_range = (i_reg <= r_reg);
        else if (side_reg)
            sts.el_in_range = (i_reg != '0);
        else
            sts.el_in_range = (i_reg <= n_reg);
    end

endmodule

// ===== rtl/block_range_add_range_sum_mod.sv =====
// Range-add / range-sum engine over a signed 64-bit array split into blocks.
// Command channel: present an item on operation and raise start; it is taken
// at a rising edge where start is high and busy is low. busy stays high until
// the item is fully handled, so one item is in flight at a time.
// Result channel: done pulses for one cycle with result; the receiver cannot
// stall it. Loads and adds that succeed give no result; a query, and any item
// with a bad index or negative modulus, gives exactly one.
// Configuration: wr_en/wr_index/wr_data write element_count (0) and
// block_length (1) at once; write only while busy is low.
// After reset the block clears all MAX_BLOCKS entries of the block sum and
// pending-add stores, one entry a cycle, with busy high.
// Steps: a load runs the serial division of l-1 by the block length, then
// the block-number wrap; an add walks the edge elements one at a time and
// the interior blocks one at a time; a query reduces the running sum after
// each element or block through a 64-bit restoring divider. An item that
// fails the check goes to the error state and answers from there.
module block_range_add_range_sum_mod
    import brs_pkg::*;
#(
    parameter int MAX_ELEMENTS = DEF_MAX_ELEMENTS,
    parameter int MAX_BLOCKS   = DEF_MAX_BLOCKS
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  in_item_t             operation,
    output logic                 done,
    output out_item_t            result,
    input  logic                 wr_en,
    input  logic [CFG_IDX_W-1:0] wr_index,
    input  logic [CFG_W-1:0]     wr_data
);

    cmd_t cmd;
    sts_t sts;

    brs_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .sts   (sts),
        .cmd   (cmd),
        .busy  (busy)
    );

    brs_dp #(
        .MAX_ELEMENTS (MAX_ELEMENTS),
        .MAX_BLOCKS   (MAX_BLOCKS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .operation (operation),
        .wr_en     (wr_en),
        .wr_index  (wr_index),
        .wr_data   (wr_data),
        .cmd       (cmd),
        .sts       (sts),
        .result    (result),
        .done      (done)
    );

endmodule

// ===== dv/block_range_add_range_sum_mod_tb.sv =====
`timescale 1ns / 1ps

module block_range_add_range_sum_mod_tb;
    import brs_pkg::*;

    localparam int N_MAX      = DEF_MAX_ELEMENTS;
    localparam int B_MAX      = DEF_MAX_BLOCKS;
    localparam int IDLE_LIMIT = 300000;
    localparam int SETTLE     = 60;

    typedef struct {
        bit                   is_cfg;
        logic [CFG_IDX_W-1:0] reg_idx;
        logic [CFG_W-1:0]     reg_data;
        in_item_t             op;
    } pending_t;

    logic                 clk;
    logic                 rst_n;
    logic                 start;
    logic                 busy;
    in_item_t             operation;
    logic                 done;
    out_item_t            result;
    logic                 wr_en;
    logic [CFG_IDX_W-1:0] wr_index;
    logic [CFG_W-1:0]     wr_data;

    block_range_add_range_sum_mod i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .operation (operation),
        .done      (done),
        .result    (result),
        .wr_en     (wr_en),
        .wr_index  (wr_index),
        .wr_data   (wr_data)
    );

    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    // predictor state
    logic [63:0] elem_val [0:N_MAX];
    logic [9:0]  blk_num  [0:N_MAX];
    logic [63:0] blk_pend [0:B_MAX-1];
    logic [63:0] blk_sum  [0:B_MAX-1];
    logic [16:0] elem_count = 17'd1;
    logic [8:0]  blk_len    = 9'd1;

    pending_t  item_q [$];
    out_item_t sum_q  [$];

    int n_mismatch, n_results, n_loads, n_adds, n_queries, n_errors, n_writes;
    int idle_cycles;
    int gap_left, settle_cnt;

    // stimulus-side view of the configuration
    int gen_n, gen_len;

    initial
    begin
        for (int b = 0; b < B_MAX; b++)
        begin
            blk_pend[b] = '0;
            blk_sum[b]  = '0;
        end
    end

    function automatic logic [63:0] trunc_rem(logic [63:0] v, logic [63:0] m);
        logic [63:0] mag;
        mag = v[63] ? -v : v;
        mag = mag % m;
        return v[63] ? -mag : mag;
    endfunction

    function automatic void push_err();
        out_item_t o;
        o.remainder = '0;
        o.status    = 1'b1;
        sum_q.push_back(o);
        n_errors++;
    endfunction

    function automatic void predict_item(in_item_t it);
        int          n, len, l, r, sid, eid, i;
        logic [63:0] v, acc, m;
        out_item_t   o;
        n   = (elem_count > N_MAX) ? N_MAX : int'(elem_count);
        len = (blk_len == 0) ? 1 : int'(blk_len);
        l   = int'(it.left_index);
        r   = int'(it.right_index);
        v   = {{32{it.operand_value[31]}}, it.operand_value};
        if (it.opcode == OP_LOAD)
        begin
            n_loads++;
            if (l < 1 || l > n)
            begin
                push_err();
                return;
            end
            sid = ((l - 1) / len + 1) % B_MAX;
            elem_val[l] = v;
            blk_num[l]  = sid[9:0];
            blk_sum[sid] += v;
            return;
        end
        if (it.opcode != OP_ADD && it.opcode != OP_QUERY)
            return;
        if (it.opcode == OP_ADD)
            n_adds++;
        else
            n_queries++;
        if (l < 1 || r > n || l > r || (it.opcode == OP_QUERY && v[63]))
        begin
            push_err();
            return;
        end
        sid = int'(blk_num[l]);
        eid = int'(blk_num[r]);
        if (it.opcode == OP_ADD)
        begin
            if (sid == eid)
            begin
                for (i = l; i <= r; i++)
                begin
                    elem_val[i] += v;
                    blk_sum[sid] += v;
                end
                return;
            end
            for (i = l; i <= n && int'(blk_num[i]) == sid; i++)
            begin
                elem_val[i] += v;
                blk_sum[sid] += v;
            end
            for (i = sid + 1; i < eid; i++)
            begin
                blk_pend[i] += v;
                blk_sum[i]  += 64'(len) * v;
            end
            for (i = r; i >= 1 && int'(blk_num[i]) == eid; i--)
            begin
                elem_val[i] += v;
                blk_sum[eid] += v;
            end
            return;
        end
        m   = v + 64'd1;
        acc = '0;
        if (sid == eid)
        begin
            for (i = l; i <= r; i++)
                acc = trunc_rem(acc + elem_val[i] + blk_pend[sid], m);
        end
        else
        begin
            for (i = l; i <= n && int'(blk_num[i]) == sid; i++)
                acc = trunc_rem(acc + elem_val[i] + blk_pend[sid], m);
            for (i = sid + 1; i < eid; i++)
                acc = trunc_rem(acc + blk_sum[i], m);
            for (i = r; i >= 1 && int'(blk_num[i]) == eid; i--)
                acc = trunc_rem(acc + elem_val[i] + blk_pend[eid], m);
        end
        o.remainder = acc[REM_W-1:0];
        o.status    = 1'b0;
        sum_q.push_back(o);
    endfunction

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        logic     taken, nx_start, nx_wr;
        in_item_t nx_op;
        logic [CFG_IDX_W-1:0] nx_idx;
        logic [CFG_W-1:0]     nx_data;
        pending_t p;
        int       g;
        int       nx_settle;
        if (!rst_n)
        begin
            start      <= 1'b0;
            operation  <= '0;
            wr_en      <= 1'b0;
            wr_index   <= '0;
            wr_data    <= '0;
            gap_left   <= 0;
            settle_cnt <= 0;
        end
        else
        begin
            taken    = start && !busy;
            nx_start = start;
            nx_op    = operation;
            nx_wr    = 1'b0;
            nx_idx   = wr_index;
            nx_data  = wr_data;
            if (taken)
                predict_item(operation);
            if (!busy && !taken && !start && sum_q.size() == 0)
                nx_settle = settle_cnt + 1;
            else
                nx_settle = 0;
            if (!start || taken)
            begin
                nx_start = 1'b0;
                if (gap_left > 0)
                    gap_left <= gap_left - 1;
                else if (item_q.size() > 0)
                begin
                    p = item_q[0];
                    if (p.is_cfg)
                    begin
                        // registers change only once the block has gone quiet
                        if (settle_cnt >= SETTLE)
                        begin
                            void'(item_q.pop_front());
                            nx_wr   = 1'b1;
                            nx_idx  = p.reg_idx;
                            nx_data = p.reg_data;
                            if (p.reg_idx == CFG_COUNT)
                                elem_count = p.reg_data[16:0];
                            else
                                blk_len = p.reg_data[8:0];
                            n_writes++;
                            nx_settle = 0;
                        end
                    end
                    else
                    begin
                        void'(item_q.pop_front());
                        nx_start = 1'b1;
                        nx_op    = p.op;
                        g = $urandom_range(0, 99);
                        if (g < 70)
                            gap_left <= 0;
                        else if (g < 95)
                            gap_left <= $urandom_range(1, 3);
                        else
                            gap_left <= $urandom_range(10, 40);
                    end
                end
            end
            settle_cnt <= nx_settle;
            start      <= nx_start;
            operation  <= nx_op;
            wr_en      <= nx_wr;
            wr_index   <= nx_idx;
            wr_data    <= nx_data;
        end
    end

    // monitor and watchdog
    always @(posedge clk)
    begin
        out_item_t want;
        if (rst_n)
        begin
            if ((start && !busy) || done)
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles > IDLE_LIMIT)
            begin
                $display("watchdog: no item or result for %0d cycles", IDLE_LIMIT);
                $display("RESULT: ERROR");
                $finish;
            end
            if (done)
            begin
                n_results++;
                if (sum_q.size() == 0)
                begin
                    n_mismatch++;
                    if (n_mismatch <= 10)
                        $display("unexpected result rem=%0d status=%0b",
                                 result.remainder, result.status);
                end
                else
                begin
                    want = sum_q.pop_front();
                    if (result.remainder !== want.remainder || result.status !== want.status)
                    begin
                        n_mismatch++;
                        if (n_mismatch <= 10)
                            $display("mismatch: rem exp %0d got %0d, status exp %0b got %0b",
                                     want.remainder, result.remainder,
                                     want.status, result.status);
                    end
                end
            end
        end
    end

    function automatic void add_op(logic [1:0] opc, int l, int r, logic [31:0] v);
        pending_t p;
        p.is_cfg              = 1'b0;
        p.reg_idx             = '0;
        p.reg_data            = '0;
        p.op.opcode           = opc;
        p.op.left_index       = l[16:0];
        p.op.right_index      = r[16:0];
        p.op.operand_value    = v;
        item_q.push_back(p);
    endfunction

    function automatic void add_cfg(logic [CFG_IDX_W-1:0] idx, int data);
        pending_t p;
        p.is_cfg   = 1'b1;
        p.reg_idx  = idx;
        p.reg_data = data[CFG_W-1:0];
        p.op       = '0;
        item_q.push_back(p);
        if (idx == CFG_COUNT)
            gen_n = data & 32'h1FFFF;
        else
            gen_len = data & 32'h1FF;
    endfunction

    // new setting, then every element in use is loaded so no unwritten entry is read
    function automatic void setup(int n, int len);
        add_cfg(CFG_COUNT, n);
        add_cfg(CFG_LENGTH, len);
        for (int i = 1; i <= n; i++)
            add_op(OP_LOAD, i, $urandom_range(0, 131071), $urandom);
    endfunction

    function automatic logic [31:0] rand_modulus();
        int k;
        k = $urandom_range(0, 9);
        if (k < 4)
            return $urandom_range(0, 100);
        else if (k < 8)
            return $urandom & 32'h7FFF_FFFF;
        else if (k == 8)
            return 32'h7FFF_FFFF;
        return 32'd0;
    endfunction

    function automatic void random_items(int cnt);
        int k, l, r;
        for (int j = 0; j < cnt; j++)
        begin
            k = $urandom_range(0, 99);
            l = $urandom_range(1, gen_n);
            r = $urandom_range(l, gen_n);
            if (k < 45)
                add_op(OP_ADD, l, r, $urandom);
            else if (k < 85)
                add_op(OP_QUERY, l, r, rand_modulus());
            else if (k < 93)
                add_op(OP_LOAD, l, $urandom_range(0, 131071), $urandom);
            else if (k < 95)
                add_op(OP_NOP, $urandom_range(0, 131071), $urandom_range(0, 131071), $urandom);
            else if (k < 97)
                add_op(OP_QUERY, l, r, $urandom | 32'h8000_0000);
            else if (k < 98)
                add_op(OP_ADD, r + 1, l, $urandom);
            else
                add_op(2'($urandom_range(0, 2)), 0, $urandom_range(gen_n + 1, 131071),
                       $urandom);
        end
    endfunction

    initial
    begin
        int rnd_left;
        rst_n     = 1'b0;
        n_mismatch = 0; n_results = 0; n_loads = 0; n_adds = 0;
        n_queries = 0; n_errors = 0; n_writes = 0; idle_cycles = 0;
        gen_n = 1; gen_len = 1;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // directed: small array, three per block
        setup(8, 3);
        add_op(OP_QUERY, 1, 8, 32'h7FFF_FFFF);
        add_op(OP_ADD, 2, 7, 32'h8000_0000);
        add_op(OP_ADD, 1, 8, 32'h7FFF_FFFF);
        add_op(OP_QUERY, 1, 8, 32'd0);
        add_op(OP_QUERY, 2, 7, 32'd6);
        add_op(OP_QUERY, 4, 5, 32'h7FFF_FFFF);
        add_op(OP_QUERY, 1, 8, 32'hFFFF_FFFF);
        add_op(OP_ADD, 0, 3, 32'd1);
        add_op(OP_QUERY, 5, 4, 32'd9);
        add_op(OP_ADD, 3, 9, 32'd1);
        add_op(OP_LOAD, 0, 0, 32'd5);
        add_op(OP_LOAD, 9, 0, 32'd5);
        add_op(OP_NOP, 1, 8, 32'd5);
        add_op(OP_LOAD, 4, 0, 32'hFFFF_FFF0);
        add_op(OP_QUERY, 3, 8, 32'd1000);

        // largest count with a block length of 256: only the top two elements are used
        add_cfg(CFG_COUNT, N_MAX);
        add_cfg(CFG_LENGTH, 256);
        add_op(OP_LOAD, N_MAX, 0, 32'h7FFF_FFFF);
        add_op(OP_LOAD, N_MAX - 1, 0, 32'h8000_0000);
        add_op(OP_ADD, N_MAX - 1, N_MAX, 32'h7FFF_FFFF);
        add_op(OP_QUERY, N_MAX - 1, N_MAX, 32'h7FFF_FFFF);
        add_op(OP_LOAD, 131071, 131071, 32'd1);
        add_op(OP_QUERY, 1, 131071, 32'd3);

        // zero block length acts as one; oversized block length
        setup(5, 0);
        random_items(6);
        setup(20, 511);
        random_items(6);
        // block numbers wrap past the block table
        setup(600, 1);
        random_items(4);
        setup(1, 1);
        random_items(4);

        rnd_left = 320;
        while (rnd_left > 0)
        begin
            setup($urandom_range(2, 32), $urandom_range(1, 7));
            random_items(80);
            rnd_left -= 80;
        end

        wait (item_q.size() == 0 && !start && sum_q.size() == 0 && !busy);
        repeat (200) @(posedge clk);
        $display("covered %0d loads, %0d adds, %0d queries, %0d register writes",
                 n_loads, n_adds, n_queries, n_writes);
        $display("%0d results checked, %0d error answers, %0d mismatches, %0d still expected",
                 n_results, n_errors, n_mismatch, sum_q.size());
        if (n_mismatch == 0 && sum_q.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
